// ===== hdl/lbft_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbft_pkg
// shared types and constants of the learning bridge forwarding table
// ----------------------------------------------------------------------------
package lbft_pkg;

   localparam int ADDR_W                = 48;
   localparam int PORT_W                = 2;
   localparam int TABLE_ENTRIES_DEFAULT = 16;
   localparam int ADDR_BITS_DEFAULT     = 48;

   localparam logic [PORT_W-1:0] FLOOD_PORT = 2'd3;

   localparam logic REQ_FRAME = 1'b0;
   localparam logic REQ_CLEAR = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE,
      ST_CLEAR
   } state_type;

   typedef struct packed {
      logic load;
      logic scan_step;
      logic finish;
      logic clear;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
   } status_type;

endpackage

// ===== hdl/lbft_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbft_ctrl
// sequencer: takes an item, then clears the table, or steps the table scan, updates and responds
// ----------------------------------------------------------------------------
module lbft_ctrl
   import lbft_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic       req_type,
   input  status_type status,
   output cmd_type    cmd,
   output logic       busy
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = (req_type == REQ_CLEAR) ? ST_CLEAR : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.scan_done) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: state_in = ST_IDLE;
         ST_CLEAR:  state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         ST_SCAN: begin
            cmd.scan_step = !status.scan_done;
         end
         ST_UPDATE: begin
            cmd.finish = 1'b1;
         end
         ST_CLEAR: begin
            cmd.clear = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

// ===== hdl/lbft_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbft_datapath
// entry memory, fill count, scan compare stage, learn update and response
// ----------------------------------------------------------------------------
module lbft_datapath
   import lbft_pkg::*;
#(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEFAULT,
   parameter int ADDR_BITS     = ADDR_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output status_type        status,
   input  logic [ADDR_W-1:0] req_src_addr,
   input  logic [PORT_W-1:0] req_src_port,
   input  logic [ADDR_W-1:0] req_dest_addr,
   output logic              rsp_valid,
   output logic [PORT_W-1:0] rsp_dest_port,
   output logic              rsp_learned,
   output logic              rsp_table_full_drop
);

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam int ENT_W = ADDR_BITS + PORT_W;
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_ENTRIES);

   // entry memory: address in the upper bits, port in the lower
   logic [ENT_W-1:0] mem [TABLE_ENTRIES];

   logic [CNT_W-1:0]     count_ff;
   logic [CNT_W-1:0]     count_in;
   logic [CNT_W-1:0]     scan_idx_ff;
   logic                 rd_vld_ff;
   logic [IDX_W-1:0]     rd_idx_ff;
   logic [ENT_W-1:0]     rd_data_ff;

   logic [ADDR_BITS-1:0] src_key_ff;
   logic [ADDR_BITS-1:0] dst_key_ff;
   logic [PORT_W-1:0]    sport_ff;

   logic                 src_hit_ff;
   logic [IDX_W-1:0]     src_idx_ff;
   logic [PORT_W-1:0]    src_old_port_ff;
   logic                 dst_hit_ff;
   logic [PORT_W-1:0]    dst_port_ff;

   logic                 rsp_valid_ff;
   logic [PORT_W-1:0]    rsp_dest_port_ff;
   logic                 rsp_learned_ff;
   logic                 rsp_full_ff;

   logic [ADDR_BITS-1:0] rd_addr;
   logic [PORT_W-1:0]    rd_port;
   logic                 src_bcast;
   logic                 dst_bcast;
   logic                 table_full;
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_idx;
   logic                 learned_in;
   logic                 full_drop_in;
   logic [PORT_W-1:0]    dport_in;

   assign rd_addr    = rd_data_ff[ENT_W-1:PORT_W];
   assign rd_port    = rd_data_ff[PORT_W-1:0];
   assign src_bcast  = &src_key_ff;
   assign dst_bcast  = &dst_key_ff;
   assign table_full = (count_ff == FULL_COUNT);

   assign status.scan_done = (scan_idx_ff == count_ff);

   // learn and lookup decision at the end of the scan
   always_comb begin
      wr_en        = 1'b0;
      wr_idx       = count_ff[IDX_W-1:0];
      learned_in   = 1'b0;
      full_drop_in = 1'b0;
      count_in     = count_ff;
      dport_in     = FLOOD_PORT;
      if (!src_bcast) begin
         if (src_hit_ff) begin
            wr_idx = src_idx_ff;
            if (src_old_port_ff != sport_ff) begin
               wr_en      = 1'b1;
               learned_in = 1'b1;
            end
         end else if (!table_full) begin
            wr_en      = 1'b1;
            learned_in = 1'b1;
            count_in   = count_ff + CNT_W'(1);
         end else begin
            full_drop_in = 1'b1;
         end
      end
      if (dst_bcast) begin
         dport_in = FLOOD_PORT;
      end else if (dst_key_ff == src_key_ff) begin
         dport_in = (src_hit_ff || !table_full) ? sport_ff : FLOOD_PORT;
      end else if (dst_hit_ff) begin
         dport_in = dst_port_ff;
      end
   end

   // memory
   always_ff @(posedge clock) begin
      if (cmd.finish && wr_en) begin
         mem[wr_idx] <= {src_key_ff, sport_ff};
      end
      if (cmd.scan_step) begin
         rd_data_ff <= mem[scan_idx_ff[IDX_W-1:0]];
         rd_idx_ff  <= scan_idx_ff[IDX_W-1:0];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         scan_idx_ff  <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_vld_ff    <= cmd.scan_step;
         rsp_valid_ff <= cmd.finish || cmd.clear;
         if (cmd.load) begin
            scan_idx_ff <= '0;
         end else if (cmd.scan_step) begin
            scan_idx_ff <= scan_idx_ff + CNT_W'(1);
         end
         if (cmd.clear) begin
            count_ff <= '0;
         end else if (cmd.finish) begin
            count_ff <= count_in;
         end
      end
   end

   // item capture, compare stage and response payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         src_key_ff <= ADDR_BITS'(req_src_addr);
         dst_key_ff <= ADDR_BITS'(req_dest_addr);
         sport_ff   <= req_src_port;
         src_hit_ff <= 1'b0;
         dst_hit_ff <= 1'b0;
      end else if (rd_vld_ff) begin
         if (rd_addr == src_key_ff) begin
            src_hit_ff      <= 1'b1;
            src_idx_ff      <= rd_idx_ff;
            src_old_port_ff <= rd_port;
         end
         if (rd_addr == dst_key_ff) begin
            dst_hit_ff  <= 1'b1;
            dst_port_ff <= rd_port;
         end
      end
      if (cmd.clear) begin
         rsp_dest_port_ff <= '0;
         rsp_learned_ff   <= 1'b0;
         rsp_full_ff      <= 1'b0;
      end else if (cmd.finish) begin
         rsp_dest_port_ff <= dport_in;
         rsp_learned_ff   <= learned_in;
         rsp_full_ff      <= full_drop_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_dest_port       = rsp_dest_port_ff;
   assign rsp_learned         = rsp_learned_ff;
   assign rsp_table_full_drop = rsp_full_ff;

endmodule

// ===== hdl/learning_bridge_forwarding_table_core.sv =====
`timescale 1ns / 1ps
// frame item: busy while the entries learned so far are scanned and the table is
// updated; result strobe rises in the cycle after the update state
// clear item: busy in the clear state, result strobe rises in the cycle after it
// next item taken as soon as busy drops; results are never held off
// the scan reads one entry per cycle from the single-port entry memory
// reset empties the table at once (fill count cleared); no clearing pass
// ----------------------------------------------------------------------------
// learning_bridge_forwarding_table_core
// learning bridge forwarding table: learns source stations, looks up dest
// ----------------------------------------------------------------------------
module learning_bridge_forwarding_table_core
   import lbft_pkg::*;
#(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEFAULT,
   parameter int ADDR_BITS     = ADDR_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic              req_type,
   input  logic [ADDR_W-1:0] req_src_addr,
   input  logic [PORT_W-1:0] req_src_port,
   input  logic [ADDR_W-1:0] req_dest_addr,
   output logic              rsp_valid,
   output logic [PORT_W-1:0] rsp_dest_port,
   output logic              rsp_learned,
   output logic              rsp_table_full_drop
);

   cmd_type    cmd;
   status_type status;

   lbft_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_type (req_type),
      .status   (status),
      .cmd      (cmd),
      .busy     (busy)
   );

   lbft_datapath #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .ADDR_BITS     (ADDR_BITS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_src_addr        (req_src_addr),
      .req_src_port        (req_src_port),
      .req_dest_addr       (req_dest_addr),
      .rsp_valid           (rsp_valid),
      .rsp_dest_port       (rsp_dest_port),
      .rsp_learned         (rsp_learned),
      .rsp_table_full_drop (rsp_table_full_drop)
   );

   // one item in flight: a result never overlaps a busy block
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_valid))
      else $error("accepted item did not start work");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_learned && rsp_table_full_drop))
      else $error("learned and dropped in one result");

   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_type == REQ_CLEAR) |=> ##1 (rsp_valid && rsp_dest_port == '0))
      else $error("clear item gave wrong result");

endmodule
